>>> sv/adps_pkg.sv
// Shared types and constants for the additive partial synthesizer.
// Used by the state memory, sine table, multiplier and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adps_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TREM_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 3'd3;

	// Fixed-point constants.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
	localparam logic [31:0] GAIN_028    = 32'd18350;
	localparam logic [15:0] LFO_BASE    = 16'd55706;
	localparam logic [31:0] LFO_DEPTH   = 32'd9830;
	localparam logic [14:0] FULL_SCALE  = 15'd32767;
	localparam logic [31:0] ENV_ONE     = 32'hFFFF_FFFF;

	// Signed sine value as magnitude and sign.
	typedef struct packed {
		logic [14:0] mag;
		logic        neg;
	} sine_t;

	// Operands of the shared multiplier.
	typedef struct packed {
		logic [32:0] a;
		logic [31:0] b;
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_ENV,
		ST_OUT
	} synth_state_t;

endpackage

`default_nettype wire

>>> sv/additive_partial_synth.sv
// Additive oscillator bank: top level with sequencer, configuration and output.
// Depends on adps_pkg, adps_state_mem, adps_sine_rom and adps_mul.
//
// Usage: every word accepted on the input channel (in_valid/in_ready) is one
// sample tick. If its restart bit is set, all phases are cleared and the
// envelope returns to unity before the sample is formed. Each tick yields
// exactly one word on the output channel (out_valid/out_ready): a signed
// 16-bit sample and a clip flag.
// Configuration words (cfg_valid/cfg_ready, cfg_index, cfg_data) set the base
// step, partial gap step, tremolo step and decay factor; cfg_ready is always
// high and unknown indexes are dropped. Write them only while the block idles.
// The state memory is read one entry per cycle, and then the single shared
// multiplier runs the four scaling products one after another.
// The result sits in an output register; the next tick is accepted while it
// waits, and a stalled receiver only holds the block once a new result is
// ready to replace it.
// Reset clears all control state, loads the register defaults and marks the
// state memory unwritten, so phases read zero and the envelope unity.
`timescale 1ns / 1ps
`default_nettype none

module additive_partial_synth import adps_pkg::*; #(
	parameter int NUM_PARTIALS    = 6,
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 restart,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [15:0]        sample,
	output logic                      clipped,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	localparam int DEPTH     = NUM_PARTIALS + 2;
	localparam int AW        = $clog2(DEPTH);
	localparam int PW        = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1;
	localparam int TREM_ADDR = NUM_PARTIALS;
	localparam int ENV_ADDR  = NUM_PARTIALS + 1;

	// Partial weights 1/k as unsigned Q16, rounded.
	logic [16:0] weight [NUM_PARTIALS];
	for (genvar g = 0; g < NUM_PARTIALS; g++) begin : g_weight
		localparam int W = (65536 + (g + 1) / 2) / (g + 1);
		assign weight[g] = 17'(W);
	end

	// Configuration registers.
	logic [31:0] base_step_q;
	logic [31:0] gap_step_q;
	logic [31:0] trem_step_q;
	logic [31:0] decay_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q <= 32'd0;
			gap_step_q  <= 32'd0;
			trem_step_q <= 32'd0;
			decay_q     <= ENV_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_STEP: base_step_q <= cfg_data;
				REG_GAP_STEP:  gap_step_q  <= cfg_data;
				REG_TREM_STEP: trem_step_q <= cfg_data;
				REG_DECAY:     decay_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state and control.
	synth_state_t state_q, state_d;
	logic [AW-1:0] cnt_q;
	logic          accept;
	logic          issue;
	logic          load_out;
	logic          clr;
	logic          mul_en;
	mul_op_t       mul_op;

	// Pipeline through memory read, sine lookup and multiply.
	logic          v_s1, v_s2, v_s3;
	logic [AW-1:0] addr_s1, addr_s2;
	logic          trem_s3;
	logic          neg_s3;
	sine_t         sine_s2;
	logic          part_s1, trem_s1, env_s1, trem_s2;

	// Datapath registers.
	logic signed [33:0] acc_q;
	logic [15:0]        lfo_q;
	logic [31:0]        env_q;
	logic [31:0]        step_q;
	logic [15:0]        res_sample_q;
	logic               res_clip_q;
	logic               out_valid_q;
	logic [15:0]        sample_q;
	logic               clipped_q;

	// Memory and multiplier connections.
	logic [31:0]   mem_rdata;
	logic          wr_en;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [64:0]   prod_q;

	// Final scaling helpers.
	logic [33:0] acc_neg;
	logic [32:0] acc_abs;
	logic [32:0] m3;
	logic        clip_now;
	logic [15:0] mag16;
	logic [13:0] dep;
	logic [33:0] part_term;

	assign part_s1 = addr_s1 < AW'(TREM_ADDR);
	assign trem_s1 = addr_s1 == AW'(TREM_ADDR);
	assign env_s1  = addr_s1 == AW'(ENV_ADDR);
	assign trem_s2 = addr_s2 == AW'(TREM_ADDR);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SCAN;
			ST_SCAN:  if (cnt_q == AW'(ENV_ADDR)) state_d = ST_DRAIN;
			ST_DRAIN: if (!v_s1 && !v_s2 && !v_s3) state_d = ST_M1;
			ST_M1:    state_d = ST_M2;
			ST_M2:    state_d = ST_M3;
			ST_M3:    state_d = ST_M4;
			ST_M4:    state_d = ST_ENV;
			ST_ENV:   state_d = ST_OUT;
			ST_OUT:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		acc_neg = -acc_q;
		acc_abs = acc_q[33] ? acc_neg[32:0] : acc_q[32:0];

		in_ready = (state_q == ST_IDLE);
		accept   = in_valid && in_ready;
		clr      = accept && restart;
		issue    = (state_q == ST_SCAN);
		load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);

		// Phase write-back from the read stage, envelope write after scaling.
		wr_en = v_s1 && (part_s1 || trem_s1);
		waddr = addr_s1;
		wdata = mem_rdata + (trem_s1 ? trem_step_q : step_q);
		if (state_q == ST_ENV) begin
			wr_en = 1'b1;
			waddr = AW'(ENV_ADDR);
			wdata = prod_q[63:32];
		end

		mul_en   = 1'b0;
		mul_op.a = 33'd0;
		mul_op.b = 32'd0;
		case (state_q)
			ST_M1: begin
				mul_en   = 1'b1;
				mul_op.a = acc_abs;
				mul_op.b = GAIN_028;
			end
			ST_M2: begin
				mul_en   = 1'b1;
				mul_op.a = {1'b0, prod_q[47:16]};
				mul_op.b = env_q;
			end
			ST_M3: begin
				mul_en   = 1'b1;
				mul_op.a = {1'b0, prod_q[63:32]};
				mul_op.b = {16'd0, lfo_q};
			end
			ST_M4: begin
				mul_en   = 1'b1;
				mul_op.a = {1'b0, env_q};
				mul_op.b = decay_q;
			end
			default: begin
				if (v_s2) begin
					mul_en   = 1'b1;
					mul_op.a = {18'd0, sine_s2.mag};
					mul_op.b = trem_s2 ? LFO_DEPTH : {15'd0, weight[addr_s2[PW-1:0]]};
				end
			end
		endcase

		m3        = prod_q[64:32];
		clip_now  = m3 > 33'(FULL_SCALE);
		mag16     = clip_now ? {1'b0, FULL_SCALE} : {1'b0, m3[14:0]};
		dep       = prod_q[28:15];
		part_term = {2'b00, prod_q[31:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + AW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1 && (part_s1 || trem_s1);
			v_s3 <= v_s2;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		addr_s2 <= addr_s1;
		trem_s3 <= trem_s2;
		neg_s3  <= sine_s2.neg;

		if (accept) begin
			acc_q  <= '0;
			step_q <= base_step_q;
		end else begin
			if (v_s1 && part_s1) begin
				step_q <= step_q + gap_step_q;
			end
			// Accumulate weighted partials; the tremolo word forms the gain.
			if (v_s3 && !trem_s3) begin
				acc_q <= neg_s3 ? (acc_q - $signed(part_term)) : (acc_q + $signed(part_term));
			end
		end
		if (v_s3 && trem_s3) begin
			lfo_q <= neg_s3 ? (LFO_BASE - {2'b00, dep}) : (LFO_BASE + {2'b00, dep});
		end
		if (v_s1 && env_s1) begin
			env_q <= mem_rdata;
		end
		if (state_q == ST_M4) begin
			res_clip_q   <= clip_now;
			res_sample_q <= acc_q[33] ? (~mag16 + 16'd1) : mag16;
		end
		if (load_out) begin
			sample_q  <= res_sample_q;
			clipped_q <= res_clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign clipped   = clipped_q;

	adps_state_mem #(
		.NUM_PARTIALS(NUM_PARTIALS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.rd_en  (issue),
		.raddr  (cnt_q),
		.rdata  (mem_rdata),
		.wr_en  (wr_en),
		.waddr  (waddr),
		.wdata  (wdata)
	);

	adps_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_rom (
		.clk    (clk),
		.en     (v_s1),
		.phase  (mem_rdata),
		.sine_q (sine_s2)
	);

	adps_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.op     (mul_op),
		.prod_q (prod_q)
	);

	// A new tick may only start with the pipeline empty.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("tick accepted while pipeline busy");

	// Pipeline multiplies never collide with the scaling sequence.
	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("pipeline multiply outside scan");

	// A restart clear never coincides with a state write.
	a_clr_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		clr |-> !wr_en)
		else $error("state write during restart clear");

	// A result appears only from the output state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("output raised outside output state");

endmodule

`default_nettype wire

>>> sv/adps_state_mem.sv
// Phase and envelope state memory with registered read.
// Per-entry valid bits give the reset value until an entry is written.
// Depends on adps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adps_state_mem import adps_pkg::*; #(
	parameter int NUM_PARTIALS = 6
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   clr,
	input  wire logic                                   rd_en,
	input  wire logic [$clog2(NUM_PARTIALS+2)-1:0]      raddr,
	output logic      [31:0]                            rdata,
	input  wire logic                                   wr_en,
	input  wire logic [$clog2(NUM_PARTIALS+2)-1:0]      waddr,
	input  wire logic [31:0]                            wdata
);

	localparam int DEPTH    = NUM_PARTIALS + 2;
	localparam int AW       = $clog2(DEPTH);
	localparam int ENV_ADDR = NUM_PARTIALS + 1;

	logic [31:0]      mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [31:0]      rdata_q;
	logic             rd_valid_q;
	logic             rd_env_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_env_q   <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[waddr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[raddr];
				rd_env_q   <= (raddr == AW'(ENV_ADDR));
			end
		end
	end

	// Unwritten phases read as zero, an unwritten envelope as unity.
	assign rdata = rd_valid_q ? rdata_q : (rd_env_q ? ENV_ONE : 32'd0);

endmodule

`default_nettype wire

>>> sv/adps_sine_rom.sv
// Quarter-wave sine table with registered lookup of a 32-bit phase.
// The table is built at elaboration from a fixed-point Taylor series.
// Depends on adps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adps_sine_rom import adps_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] phase,
	output sine_t            sine_q
);

	localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
	localparam int J_W     = SINE_TABLE_BITS - 1;

	function automatic logic [14:0] quarter_sine(input int unsigned j);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] inner;
		logic [63:0] sub;
		logic [63:0] s;
		logic [63:0] mag;
		x = (HALF_PI_Q30 * 64'(j)) / QUARTER;
		x2 = (x * x) >> 30;
		inner = Q30_ONE;
		for (int d = 0; d < 6; d++) begin
			sub = ((x2 * inner) >> 30) / TAYLOR_DIV[d];
			inner = (sub > Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
		end
		s = (x * inner) >> 30;
		mag = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
		if (mag > 64'(FULL_SCALE)) begin
			mag = 64'(FULL_SCALE);
		end
		return mag[14:0];
	endfunction

	logic [14:0] mag_tab [QUARTER+1];

	for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
		localparam logic [14:0] MAG = quarter_sine(g);
		assign mag_tab[g] = MAG;
	end

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                 quad;
	logic [J_W-1:0]             r_ext;
	logic [J_W-1:0]             j;

	always_comb begin
		idx   = phase[31 -: SINE_TABLE_BITS];
		quad  = idx[SINE_TABLE_BITS-1 -: 2];
		r_ext = {1'b0, idx[SINE_TABLE_BITS-3:0]};
		// Odd quadrants run the table backward.
		j     = quad[0] ? (J_W'(QUARTER) - r_ext) : r_ext;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine_q.mag <= mag_tab[j];
			sine_q.neg <= quad[1];
		end
	end

endmodule

`default_nettype wire

>>> sv/adps_mul.sv
// Shared 33 x 32 unsigned multiplier with a registered product.
// Depends on adps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adps_mul import adps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire mul_op_t     op,
	output logic      [64:0] prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 65'(op.a) * 65'(op.b);
		end
	end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the additive partial synthesizer (additive_partial_synth).
// A directed table followed by random phases, checked against a sample predictor kept here.
// Depends on adps_pkg and the RTL under sv/.
`timescale 1ns / 1ps

module testbench;
	import adps_pkg::*;

	// Sizes of the oscillator bank, kept in step with the instance below.
	localparam int NPART   = 6;
	localparam int ROMBITS = 10;
	localparam int QTR     = (1 << ROMBITS) / 4;

	// Fixed-point constants of the sample arithmetic.
	localparam logic [63:0] HALF_PI_FX  = 64'd1686629713;
	localparam logic [63:0] ONE_FX      = 64'd1 << 30;
	localparam logic [63:0] MIX_GAIN    = 64'd18350;
	localparam logic [63:0] TREM_CENTER = 64'd55706;
	localparam logic [63:0] TREM_DEPTH  = 64'd9830;
	localparam logic [63:0] PCM_MAX     = 64'd32767;

	// An index that names no register; writes to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// The watchdog gives up after this many cycles with no word moving on any channel.
	// The longest quiet stretch of a correct run is the deliberate receiver hold-off.
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	// Cycles allowed for the block to settle after its last result before a register write.
	localparam int SETTLE       = 24;
	localparam int PHASE_TICKS  = 140;
	localparam int NUM_PHASES   = 8;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// One row of the directed table: either a register write or one sample tick.
	// A tick row with lit set carries its expected word; otherwise the predictor decides.
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [31:0]           data;
		logic                  rst;
		logic                  lit;
		logic [15:0]           smp;
		logic                  clp;
	} dir_row_t;

	typedef struct packed {
		logic [15:0] smp;
		logic        clp;
	} pcm_word_t;

	localparam int NUM_ROWS = 28;
	localparam dir_row_t DIRECTED [NUM_ROWS] = '{
		// Out of reset every phase reads zero, so the mix is silent.
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b1, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b1, 1'b1, 16'h0000, 1'b0},
		// A quarter-cycle step walks all partials through the four quadrants.
		'{ROW_CFG,  REG_BASE_STEP, 32'h4000_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b1, 1'b1, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b1, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		// A zero decay factor kills the envelope after one sample.
		'{ROW_CFG,  REG_DECAY, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b1, 1'b1, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b1, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b1, 16'h0000, 1'b0},
		'{ROW_CFG,  REG_DECAY, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b1, 1'b1, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		// Largest gap, so partial steps wrap around.
		'{ROW_CFG,  REG_GAP_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  REG_TREM_STEP, 32'h4000_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		// All steps at their maximum.
		'{ROW_CFG,  REG_BASE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  REG_TREM_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b1, 1'b1, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		// A write to an unused index must leave every register alone.
		'{ROW_CFG,  REG_UNUSED, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_CFG,  REG_GAP_STEP, 32'h0100_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ROW_TICK, REG_BASE_STEP, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0}
	};

	// Everything the testbench drives starts at a known value.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic restart = 1'b0;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_ready, out_valid, clipped, cfg_ready;
	logic signed [15:0] sample;

	// Side information that travels with the tick word currently offered.
	logic        word_lit = 1'b0;
	logic [15:0] word_smp = '0;
	logic        word_clp = 1'b0;

	additive_partial_synth #(
		.NUM_PARTIALS(NPART),
		.SINE_TABLE_BITS(ROMBITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.clipped(clipped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Sample predictor. It holds its own copy of the registers and of the
	// oscillator state and is advanced once per accepted tick word.
	// ------------------------------------------------------------------
	int          quarter_wave [0:QTR];
	logic [31:0] p_base, p_gap, p_trem, p_decay;
	logic [31:0] p_phase [NPART];
	logic [31:0] p_trem_phase;
	logic [31:0] p_env;

	// Quarter-wave magnitudes from a Taylor series evaluated in Q30.
	initial begin
		logic [63:0] x, x2, inner, sub, s, mag;
		logic [63:0] divs [6];
		divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		for (int j = 0; j <= QTR; j++) begin
			x = (HALF_PI_FX * 64'(j)) / 64'(QTR);
			x2 = (x * x) >> 30;
			inner = ONE_FX;
			for (int d = 0; d < 6; d++) begin
				sub = ((x2 * inner) >> 30) / divs[d];
				inner = (sub > ONE_FX) ? 64'd0 : ONE_FX - sub;
			end
			s = (x * inner) >> 30;
			mag = (s * PCM_MAX + (64'd1 << 29)) >> 30;
			if (mag > PCM_MAX)
				mag = PCM_MAX;
			quarter_wave[j] = int'(mag);
		end
	end

	// Signed sine of a phase, folding the top address bits onto the quarter wave.
	function automatic int phase_sine(input logic [31:0] phase);
		logic [ROMBITS-1:0] addr;
		logic [1:0]         quad;
		int                 r, mag;
		addr = phase[31 -: ROMBITS];
		quad = addr[ROMBITS-1 -: 2];
		r = int'(addr[ROMBITS-3:0]);
		mag = quad[0] ? quarter_wave[QTR - r] : quarter_wave[r];
		return quad[1] ? -mag : mag;
	endfunction

	// Forms the next PCM word and advances the oscillators and the envelope.
	function automatic pcm_word_t predict_sample(input logic rst);
		longint      mix, w;
		logic [63:0] m, m1, m2, m3, dep, gain;
		int          st;
		logic        neg;
		pcm_word_t   r;
		if (rst) begin
			foreach (p_phase[k])
				p_phase[k] = '0;
			p_trem_phase = '0;
			p_env = 32'hFFFF_FFFF;
		end
		mix = 0;
		for (int k = 0; k < NPART; k++) begin
			w = longint'((65536 + (k + 1) / 2) / (k + 1));
			mix += longint'(phase_sine(p_phase[k])) * w;
		end
		st = phase_sine(p_trem_phase);
		dep = (TREM_DEPTH * 64'(st < 0 ? -st : st)) >> 15;
		gain = (st < 0) ? TREM_CENTER - dep : TREM_CENTER + dep;
		neg = mix < 0;
		m = neg ? 64'(-mix) : 64'(mix);
		m1 = (m * MIX_GAIN) >> 16;
		m2 = (m1 * 64'(p_env)) >> 32;
		m3 = (m2 * gain) >> 32;
		r.clp = 1'b0;
		if (m3 > PCM_MAX) begin
			m3 = PCM_MAX;
			r.clp = 1'b1;
		end
		r.smp = neg ? 16'(-m3) : 16'(m3);
		for (int k = 0; k < NPART; k++)
			p_phase[k] = p_phase[k] + p_base + 32'(k) * p_gap;
		p_trem_phase = p_trem_phase + p_trem;
		p_env = 32'((64'(p_env) * 64'(p_decay)) >> 32);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Monitor. All three channels are sampled at the rising edge, where the
	// block's registered outputs still hold their values from before the edge.
	// ------------------------------------------------------------------
	pcm_word_t pending_samples [$];
	int errors = 0;
	int n_checked = 0, n_restarts = 0, n_clipped = 0, n_nonzero = 0, n_writes = 0;

	always @(posedge clk) begin
		pcm_word_t want;
		if (!arst_n) begin
			p_base = '0;
			p_gap = '0;
			p_trem = '0;
			p_decay = 32'hFFFF_FFFF;
			foreach (p_phase[k])
				p_phase[k] = '0;
			p_trem_phase = '0;
			p_env = 32'hFFFF_FFFF;
		end else begin
			if (cfg_valid && cfg_ready) begin
				n_writes++;
				case (cfg_index)
					REG_BASE_STEP: p_base = cfg_data;
					REG_GAP_STEP:  p_gap = cfg_data;
					REG_TREM_STEP: p_trem = cfg_data;
					REG_DECAY:     p_decay = cfg_data;
					default: ;
				endcase
			end
			// A tick word is accepted: the predictor always runs so its state
			// stays in step, but a table row with a typed-in word checks that instead.
			if (in_valid && in_ready) begin
				want = predict_sample(restart);
				if (word_lit) begin
					want.smp = word_smp;
					want.clp = word_clp;
				end
				if (restart)
					n_restarts++;
				pending_samples.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (pending_samples.size() == 0) begin
					$display("%0t: output word with nothing outstanding, sample %0d clipped %0b",
						$time, sample, clipped);
					errors++;
				end else begin
					want = pending_samples.pop_front();
					n_checked++;
					if (clipped)
						n_clipped++;
					if (sample != 0)
						n_nonzero++;
					if (sample !== want.smp) begin
						$display("%0t: sample mismatch, expected %0d, got %0d",
							$time, $signed(want.smp), sample);
						errors++;
					end
					if (clipped !== want.clp) begin
						$display("%0t: clipped mismatch, expected %0b, got %0b",
							$time, want.clp, clipped);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: counts cycles in which no word moves on any channel.
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver. It stalls at random with the chance the driver sets, and on
	// request holds off for a long stretch, counted here, so that the block
	// fills up and has to stall its input.
	// ------------------------------------------------------------------
	int unsigned stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			out_ready <= 1'b0;
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Sender side: tick words and register writes, driven at the falling edge.
	// ------------------------------------------------------------------
	int unsigned gap_pct = 0;

	// Waits until every expected word has come back and the block has settled,
	// and lowers the tick valid so no word is on offer meanwhile.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offers one tick word. Valid is left high after acceptance so that a
	// following word goes out back to back; an idle gap lowers it first.
	task automatic send_tick(input logic rst, input logic lit, input logic [15:0] smp,
			input logic clp);
		@(negedge clk);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		restart <= rst;
		word_lit <= lit;
		word_smp <= smp;
		word_clp <= clp;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic set_idling(input idle_mode_t mode);
		gap_pct = (mode == IDLE_SEND) ? 49 : (mode == IDLE_BOTH) ? 38 : 0;
		stall_pct = (mode == IDLE_RECV) ? 49 : (mode == IDLE_BOTH) ? 38 : 0;
	endtask

	initial begin
		logic [31:0] base, gap, trem, decay;
		int unsigned restart_odds;
		idle_mode_t mode;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: register writes happen only once the block is idle.
		set_idling(IDLE_NONE);
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				send_tick(DIRECTED[i].rst, DIRECTED[i].lit, DIRECTED[i].smp, DIRECTED[i].clp);
			end
		end

		// Random phases, each with its own register setting and idling pattern.
		for (int p = 0; p < NUM_PHASES; p++) begin
			restart_odds = 16;
			case (p)
				1: begin
					// Every register at its maximum.
					base = 32'hFFFF_FFFF;
					gap = 32'hFFFF_FFFF;
					trem = 32'hFFFF_FFFF;
					decay = 32'hFFFF_FFFF;
				end
				2: begin
					// Every register at its minimum; restarts give the only
					// non-silent envelope, so they come more often.
					base = '0;
					gap = '0;
					trem = '0;
					decay = '0;
					restart_odds = 4;
				end
				default: begin
					base = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0200_0000);
					gap = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0100_0000);
					trem = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0010_0000);
					decay = ($urandom_range(0, 3) == 0) ? $urandom :
						(32'hFFF0_0000 | $urandom_range(0, 32'h000F_FFFF));
				end
			endcase
			wait_idle();
			write_reg(REG_BASE_STEP, base);
			write_reg(REG_GAP_STEP, gap);
			write_reg(REG_TREM_STEP, trem);
			write_reg(REG_DECAY, decay);
			if ($urandom_range(0, 1))
				write_reg(3'($urandom_range(4, 7)), $urandom);

			mode = idle_mode_t'(p % 4);
			set_idling(mode);
			// In one phase the receiver holds off while the sender keeps going.
			if (p == 4)
				hold_requests++;
			for (int n = 0; n < PHASE_TICKS; n++)
				send_tick($urandom_range(1, restart_odds) == 1, 1'b0, 16'h0000, 1'b0);
		end

		// Drain: the sender stops and waits for every outstanding word.
		wait_idle();
		repeat (40) @(posedge clk);

		$display("Checked %0d sample words (%0d restarts, %0d nonzero, %0d clipped).",
			n_checked, n_restarts, n_nonzero, n_clipped);
		$display("Register writes: %0d over %0d random phases with varied idling.",
			n_writes, NUM_PHASES);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
